FILE: hw/rtl/gbd_pkg.sv
// shared types and constants for the grid distance map unit
// no dependencies
package gbd_pkg;

	localparam int XW    = 9;
	localparam int YW    = 8;
	localparam int DW    = 10;
	localparam int FE_W  = XW + YW;

	localparam logic [DW-1:0] FAR_VALUE = 10'd1000;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_SEED  = 2'd1;
	localparam logic [1:0] REQ_GROW  = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [XW-1:0] RESET_WIDTH  = 9'd320;
	localparam logic [YW-1:0] RESET_HEIGHT = 8'd240;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED,
		ST_READ,
		ST_READ_WAIT,
		ST_FETCH,
		ST_ENTRY,
		ST_NRD,
		ST_NCHK,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/gbd_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module gbd_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 76800
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/grid_bfs_distance_map_unit.sv
// grid distance map: clear, seed, breadth-first grow and read requests
// grow works level by level: each frontier entry is fetched and checked, then each
// neighbor probed on the grid ram is read and then checked; the unit takes
// one request at a time
// after reset the grid ram is swept to far at every cell, no item taken
// depends on gbd_pkg and gbd_ram
module grid_bfs_distance_map_unit #(
	parameter int MAX_WIDTH  = 320,
	parameter int MAX_HEIGHT = 240,
	parameter int MAX_LEVELS = 40
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [gbd_pkg::XW-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             req_type,
	input  logic [gbd_pkg::XW-1:0] cell_x,
	input  logic [gbd_pkg::YW-1:0] cell_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [gbd_pkg::DW-1:0] distance,
	output logic                   frontier_overflow
);
	import gbd_pkg::*;

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int LW    = $clog2(MAX_LEVELS);

	state_t state_q, state_d;

	logic [XW-1:0] width_q;
	logic [YW-1:0] height_q;
	logic [1:0]    req_q;
	logic [XW-1:0] rx_q, fx_q;
	logic [YW-1:0] ry_q, fy_q;
	logic          cur_sel_q;
	logic [CW-1:0] cur_cnt_q, nxt_cnt_q, ent_idx_q;
	logic [LW-1:0] level_q;
	logic [2:0]    nb_q;
	logic [AW-1:0] nidx_q, clr_addr_q;
	logic          clr_resp_q;
	logic [DW-1:0] res_dist_q, dist_q;
	logic          res_ovf_q, ovf_q, out_valid_q;

	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	logic [AW-1:0] req_idx, nb_idx;
	logic [XW-1:0] nx, ex;
	logic [YW-1:0] ny, ey;
	logic          req_in_grid, seed_push, grow_push, entry_skip, last_nb;
	logic          slot_free;

	logic          grid_we;
	logic [AW-1:0] grid_waddr, grid_raddr;
	logic [DW-1:0] grid_wdata, grid_rdata;
	logic          fa_we, fb_we;
	logic [AW-1:0] fr_waddr, fr_raddr;
	logic [FE_W-1:0] fr_wdata, fa_rdata, fb_rdata, cur_rdata;

	assign w_eff = (32'(width_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : width_q;
	assign h_eff = (32'(height_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : height_q;

	assign req_in_grid = (rx_q < w_eff) && (ry_q < h_eff);
	assign req_idx = AW'(rx_q) + AW'(ry_q) * AW'(w_eff);

	// neighbor order: right, left, down, up, then the four diagonals
	always_comb begin
		nx = fx_q;
		ny = fy_q;
		case (nb_q)
			3'd0: nx = fx_q + 1'b1;
			3'd1: nx = fx_q - 1'b1;
			3'd2: ny = fy_q + 1'b1;
			3'd3: ny = fy_q - 1'b1;
			3'd4: begin
				nx = fx_q + 1'b1;
				ny = fy_q + 1'b1;
			end
			3'd5: begin
				nx = fx_q - 1'b1;
				ny = fy_q + 1'b1;
			end
			3'd6: begin
				nx = fx_q - 1'b1;
				ny = fy_q - 1'b1;
			end
			default: begin
				nx = fx_q + 1'b1;
				ny = fy_q - 1'b1;
			end
		endcase
	end

	assign nb_idx  = AW'(nx) + AW'(ny) * AW'(w_eff);
	assign last_nb = level_q[0] ? (nb_q == 3'd7) : (nb_q == 3'd3);

	assign cur_rdata = cur_sel_q ? fb_rdata : fa_rdata;
	assign ex = cur_rdata[XW-1:0];
	assign ey = cur_rdata[FE_W-1:XW];
	// stale entries and border cells are not expanded
	assign entry_skip = (ex >= w_eff) || (ey >= h_eff) || (ex == '0) || (ey == '0)
		|| (({1'b0, ex} + 10'd1) == {1'b0, w_eff})
		|| (({1'b0, ey} + 9'd1) == {1'b0, h_eff});

	assign seed_push = (state_q == ST_SEED) && req_in_grid && (32'(cur_cnt_q) < CELLS);
	assign grow_push = (state_q == ST_NCHK) && (grid_rdata > DW'(level_q))
		&& (32'(nxt_cnt_q) < CELLS);

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	// grid ram ports
	always_comb begin
		grid_we    = 1'b0;
		grid_waddr = nidx_q;
		grid_wdata = DW'(level_q);
		grid_raddr = nb_idx;
		case (state_q)
			ST_CLEAR: begin
				grid_we    = 1'b1;
				grid_waddr = clr_addr_q;
				grid_wdata = FAR_VALUE;
			end
			ST_SEED: begin
				grid_we    = seed_push;
				grid_waddr = req_idx;
				grid_wdata = '0;
			end
			ST_READ: grid_raddr = req_idx;
			ST_NCHK: grid_we = grow_push;
			default: ;
		endcase
	end

	// frontier rams swap roles at each level
	assign fr_waddr = seed_push ? cur_cnt_q[AW-1:0] : nxt_cnt_q[AW-1:0];
	assign fr_wdata = seed_push ? {ry_q, rx_q} : {ny, nx};
	assign fr_raddr = ent_idx_q[AW-1:0];
	assign fa_we = (seed_push && !cur_sel_q) || (grow_push && cur_sel_q);
	assign fb_we = (seed_push && cur_sel_q) || (grow_push && !cur_sel_q);

	gbd_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_grid (
		.clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
		.raddr(grid_raddr), .rdata(grid_rdata)
	);

	gbd_ram #(.WIDTH(FE_W), .DEPTH(CELLS)) u_front_a (
		.clk(clk), .we(fa_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fa_rdata)
	);

	gbd_ram #(.WIDTH(FE_W), .DEPTH(CELLS)) u_front_b (
		.clk(clk), .we(fb_we), .waddr(fr_waddr), .wdata(fr_wdata),
		.raddr(fr_raddr), .rdata(fb_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (32'(clr_addr_q) == CELLS - 1) begin
					state_d = clr_resp_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (req_type)
						REQ_CLEAR: state_d = ST_CLEAR;
						REQ_SEED:  state_d = ST_SEED;
						REQ_GROW:  state_d = ST_FETCH;
						default:   state_d = ST_READ;
					endcase
				end
			end
			ST_SEED:      state_d = ST_DONE;
			ST_READ:      state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_DONE;
			ST_FETCH: begin
				if (ent_idx_q == cur_cnt_q) begin
					if (32'(level_q) == MAX_LEVELS - 1) begin
						state_d = ST_DONE;
					end
				end else begin
					state_d = ST_ENTRY;
				end
			end
			ST_ENTRY: state_d = entry_skip ? ST_FETCH : ST_NRD;
			ST_NRD:   state_d = ST_NCHK;
			ST_NCHK:  state_d = last_nb ? ST_FETCH : ST_NRD;
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= RESET_WIDTH;
			height_q    <= RESET_HEIGHT;
			cur_sel_q   <= 1'b0;
			cur_cnt_q   <= '0;
			nxt_cnt_q   <= '0;
			ent_idx_q   <= '0;
			level_q     <= '0;
			nb_q        <= '0;
			clr_addr_q  <= '0;
			clr_resp_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  width_q <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data[YW-1:0];
					default: ;
				endcase
			end
			if ((state_q == ST_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					cur_cnt_q  <= '0;
					nxt_cnt_q  <= '0;
				end
				ST_IDLE: begin
					clr_addr_q <= '0;
					clr_resp_q <= 1'b1;
					level_q    <= LW'(1);
					nxt_cnt_q  <= '0;
					ent_idx_q  <= '0;
				end
				ST_SEED: begin
					if (seed_push) begin
						cur_cnt_q <= cur_cnt_q + 1'b1;
					end
				end
				ST_FETCH: begin
					if (ent_idx_q == cur_cnt_q) begin
						ent_idx_q <= '0;
						nxt_cnt_q <= '0;
						if (32'(level_q) == MAX_LEVELS - 1) begin
							cur_cnt_q <= '0;
							level_q   <= '0;
						end else begin
							cur_sel_q <= !cur_sel_q;
							cur_cnt_q <= nxt_cnt_q;
							level_q   <= level_q + 1'b1;
						end
					end
				end
				ST_ENTRY: begin
					nb_q <= '0;
					if (entry_skip) begin
						ent_idx_q <= ent_idx_q + 1'b1;
					end
				end
				ST_NRD: ;
				ST_NCHK: begin
					nb_q <= nb_q + 1'b1;
					if (grow_push) begin
						nxt_cnt_q <= nxt_cnt_q + 1'b1;
					end
					if (last_nb) begin
						ent_idx_q <= ent_idx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q      <= req_type;
				rx_q       <= cell_x;
				ry_q       <= cell_y;
				res_dist_q <= '0;
				res_ovf_q  <= 1'b0;
			end
			ST_SEED: res_ovf_q <= req_in_grid && (32'(cur_cnt_q) >= CELLS);
			ST_READ_WAIT: res_dist_q <= req_in_grid ? grid_rdata : FAR_VALUE;
			ST_ENTRY: begin
				fx_q <= ex;
				fy_q <= ey;
			end
			ST_NRD: nidx_q <= nb_idx;
			ST_DONE: begin
				if (slot_free) begin
					dist_q <= res_dist_q;
					ovf_q  <= res_ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid         = out_valid_q;
	assign distance          = dist_q;
	assign frontier_overflow = ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(nxt_cnt_q) <= CELLS) && (32'(cur_cnt_q) <= CELLS))
		else $error("frontier count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (nxt_cnt_q == '0))
		else $error("next frontier not empty between requests");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (req_q != REQ_READ) |-> (res_dist_q == '0))
		else $error("non-read request carries a distance");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (req_q == REQ_GROW) |-> (level_q == '0) && (cur_cnt_q == '0))
		else $error("grow ended with frontier or level left over");

endmodule
